// ===== rtl/vde_pkg.sv =====
package vde_pkg;

   localparam int SUM_W = 48;
   localparam int ELEM_W = 16;

   localparam logic [1:0] METRIC_L2     = 2'd0;
   localparam logic [1:0] METRIC_COSINE = 2'd1;
   localparam logic [1:0] METRIC_INNER  = 2'd2;

   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
   localparam logic signed [SUM_W-1:0] ONE_Q16 = 48'sd65536;

   // one finished row handed from front to back
   typedef struct packed {
      logic                    cosine;
      logic signed [SUM_W-1:0] main_sum;
      logic signed [SUM_W-1:0] qnorm;
      logic signed [SUM_W-1:0] cnorm;
   } row_type;

   // saturating 48 bit add of a term already within range
   function automatic logic signed [SUM_W-1:0] sat_add(
      input logic signed [SUM_W-1:0] a,
      input logic signed [SUM_W-1:0] b);
      logic signed [SUM_W:0] s;
      s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
      if (s[SUM_W] != s[SUM_W-1])
         return s[SUM_W] ? SUM_MIN : SUM_MAX;
      return s[SUM_W-1:0];
   endfunction

endpackage

// ===== rtl/vde_front.sv =====
module vde_front
   import vde_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic [1:0]               metric,
   input  logic                     in_valid,
   output logic                     in_stall,
   input  logic signed [ELEM_W-1:0] qe,
   input  logic signed [ELEM_W-1:0] ce,
   input  logic                     last,
   output logic                     row_valid,
   input  logic                     row_stall,
   output row_type                  row
);

   // element stage registers: squares and product
   logic                    s1_valid_ff, s1_valid_in;
   logic                    s1_last_ff;
   logic                    s1_cos_ff;
   logic signed [SUM_W-1:0] s1_main_ff, s1_q_ff, s1_c_ff;
   logic signed [SUM_W-1:0] acc_main_ff, acc_q_ff, acc_c_ff;
   logic signed [SUM_W-1:0] nm, nq, nc;
   logic signed [ELEM_W:0]  diff;
   logic                    row_valid_ff;
   row_type                 row_ff;
   logic                    adv;

   // a product beat can only move when the row slot is free
   assign adv       = !(row_valid_ff && row_stall);
   assign in_stall  = !adv;
   assign row_valid = row_valid_ff;
   assign row       = row_ff;
   assign diff      = {qe[ELEM_W-1], qe} - {ce[ELEM_W-1], ce};
   assign s1_valid_in = in_valid && adv;

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_last_ff <= last;
         s1_cos_ff  <= (metric == METRIC_COSINE);
         if ((metric == METRIC_COSINE) || (metric == METRIC_INNER))
            s1_main_ff <= SUM_W'(qe * ce);
         else
            s1_main_ff <= SUM_W'(diff * diff);
         s1_q_ff <= SUM_W'(qe * qe);
         s1_c_ff <= SUM_W'(ce * ce);
      end
   end

   // accumulate and hand off at row end
   always_comb begin
      nm = sat_add(acc_main_ff, s1_main_ff);
      nq = sat_add(acc_q_ff, s1_q_ff);
      nc = sat_add(acc_c_ff, s1_c_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         row_valid_ff <= 1'b0;
         acc_main_ff  <= '0;
         acc_q_ff     <= '0;
         acc_c_ff     <= '0;
      end else begin
         if (adv) s1_valid_ff <= s1_valid_in;
         row_valid_ff <= (s1_valid_ff && adv && s1_last_ff) || (row_valid_ff && row_stall);
         if (s1_valid_ff && adv) begin
            if (s1_last_ff) begin
               acc_main_ff  <= '0;
               acc_q_ff     <= '0;
               acc_c_ff     <= '0;
               row_ff.main_sum <= nm;
               row_ff.qnorm    <= nq;
               row_ff.cnorm    <= nc;
               row_ff.cosine   <= s1_cos_ff;
            end else begin
               acc_main_ff <= nm;
               acc_q_ff    <= nq;
               acc_c_ff    <= nc;
            end
         end
      end
   end

endmodule

// ===== rtl/vde_queue.sv =====
module vde_queue
   import vde_pkg::*;
#(
   parameter int DEPTH = 2
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_valid,
   output logic    wr_stall,
   input  row_type wr_data,
   output logic    rd_valid,
   input  logic    rd_stall,
   output row_type rd_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   row_type         mem [DEPTH];
   logic [AW-1:0]   wp_ff, rp_ff;
   logic [AW:0]     cnt_ff;
   logic            wr, rd;

   assign wr_stall = (cnt_ff == (AW+1)'(DEPTH));
   assign rd_valid = (cnt_ff != '0);
   assign rd_data  = mem[rp_ff];
   assign wr       = wr_valid && !wr_stall;
   assign rd       = rd_valid && !rd_stall;

   always_ff @(posedge clock) begin
      if (wr) mem[wp_ff] <= wr_data;
   end

   // pointers wrap at depth
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (wr) wp_ff <= (wp_ff == AW'(DEPTH-1)) ? '0 : wp_ff + 1'b1;
         if (rd) rp_ff <= (rp_ff == AW'(DEPTH-1)) ? '0 : rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (AW+1)'(wr) - (AW+1)'(rd);
      end
   end

endmodule

// ===== rtl/vde_back.sv =====
module vde_back
   import vde_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    row_valid,
   output logic                    row_stall,
   input  row_type                 row,
   output logic                    out_valid,
   input  logic                    out_stall,
   output logic signed [SUM_W-1:0] out_dist
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_SQRT = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_FIN  = 3'd4;
   localparam logic [2:0] ST_OUT  = 3'd5;

   // largest quotients whose offset result stays in range
   localparam logic [48:0] Q_POS_LIMIT = 49'(SUM_MAX - ONE_Q16);
   localparam logic [48:0] Q_NEG_LIMIT = 49'(SUM_MAX) + 49'(ONE_Q16) + 49'd1;

   logic [2:0]              st_ff;
   logic [6:0]              cnt_ff;
   logic [95:0]             prod_ff;
   logic [1:0]              mp_ff;
   logic [47:0]             qn_ff, cn_ff;
   logic [97:0]             rem_ff;
   logic [47:0]             root_ff;
   logic [63:0]             num_ff;
   logic [48:0]             drem_ff;
   logic [63:0]             quo_ff;
   logic                    neg_ff;
   logic signed [SUM_W-1:0] dist_ff;
   logic [97:0]             trial;
   logic [97:0]             rem_sh;
   logic [48:0]             dsh;
   logic [23:0]             qpart;
   logic [48:0]             q49;

   assign row_stall = (st_ff != ST_IDLE);
   assign out_valid = (st_ff == ST_OUT);
   assign out_dist  = dist_ff;

   // sqrt: restoring, two bits of radicand per step
   always_comb begin
      rem_sh = {rem_ff[95:0], prod_ff[95:94]};
      trial  = {48'd0, root_ff, 2'b01};
   end
   assign dsh = {drem_ff[47:0], num_ff[63]};
   // partial multiply operand: 24 bit slice of candidate norm
   assign qpart = mp_ff[0] ? cn_ff[47:24] : cn_ff[23:0];
   assign q49 = (quo_ff > 64'h1_0000_0000_0000) ? 49'h1_0000_0000_0000 : quo_ff[48:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
      end else begin
         case (st_ff)
            ST_IDLE: begin
               if (row_valid) begin
                  neg_ff  <= row.main_sum[SUM_W-1];
                  num_ff  <= {(row.main_sum[SUM_W-1] ? 48'(-row.main_sum)
                                                      : 48'(row.main_sum)), 16'd0};
                  qn_ff   <= row.qnorm;
                  cn_ff   <= row.cnorm;
                  prod_ff <= '0;
                  mp_ff   <= '0;
                  if (!row.cosine) begin
                     dist_ff <= row.main_sum;
                     st_ff   <= ST_OUT;
                  end else if (row.qnorm[SUM_W-1] || row.qnorm == '0 ||
                               row.cnorm[SUM_W-1] || row.cnorm == '0) begin
                     dist_ff <= ONE_Q16;
                     st_ff   <= ST_OUT;
                  end else begin
                     st_ff <= ST_MUL;
                  end
               end
            end
            // 48x24 partial products, low slice then high slice
            ST_MUL: begin
               if (mp_ff[0]) begin
                  prod_ff <= prod_ff + ({24'd0, 72'(qn_ff * qpart)} << 24);
                  rem_ff  <= '0;
                  root_ff <= '0;
                  cnt_ff  <= '0;
                  st_ff   <= ST_SQRT;
               end else begin
                  prod_ff <= 96'(qn_ff * qpart);
               end
               mp_ff <= mp_ff + 2'd1;
            end
            ST_SQRT: begin
               prod_ff <= {prod_ff[93:0], 2'b00};
               if (rem_sh >= trial) begin
                  rem_ff  <= rem_sh - trial;
                  root_ff <= {root_ff[46:0], 1'b1};
               end else begin
                  rem_ff  <= rem_sh;
                  root_ff <= {root_ff[46:0], 1'b0};
               end
               if (cnt_ff == 7'd47) begin
                  st_ff  <= ST_DIV;
                  cnt_ff <= '0;
                  drem_ff <= '0;
               end else begin
                  cnt_ff <= cnt_ff + 7'd1;
               end
            end
            // restoring divide, one quotient bit per cycle
            ST_DIV: begin
               if (cnt_ff == 7'd0 && root_ff == '0) begin
                  dist_ff <= ONE_Q16;
                  st_ff   <= ST_OUT;
               end else begin
                  num_ff <= {num_ff[62:0], 1'b0};
                  if (dsh >= {1'b0, root_ff}) begin
                     drem_ff <= dsh - {1'b0, root_ff};
                     quo_ff  <= {quo_ff[62:0], 1'b1};
                  end else begin
                     drem_ff <= dsh;
                     quo_ff  <= {quo_ff[62:0], 1'b0};
                  end
                  if (cnt_ff == 7'd63) st_ff <= ST_FIN;
                  cnt_ff <= cnt_ff + 7'd1;
               end
            end
            // offset from one, clamped to the sum range
            ST_FIN: begin
               if (neg_ff)
                  dist_ff <= (q49 > Q_POS_LIMIT) ? SUM_MAX : ONE_Q16 + SUM_W'(q49);
               else
                  dist_ff <= (q49 > Q_NEG_LIMIT) ? SUM_MIN : ONE_Q16 - SUM_W'(q49);
               st_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (!out_stall) st_ff <= ST_IDLE;
            end
            default: st_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

// ===== rtl/vector_distance_engine.sv =====
// Vector distance engine: element pairs stream in one beat per cycle, unless
// req_stall holds them, with a last flag closing each row; one 48 bit distance
// comes out per row (16 fractional bits for cosine, integer sums for L2 and inner
// product). Squares and products are formed and accumulated in a two stage front
// pipe at one beat per cycle while not stalled. Finished rows pass through a queue
// (two entries by default) to a back unit; cosine rows take 2 multiply, 48 square
// root and 64 divide steps there, while L2 and inner product rows pass straight out.
module vector_distance_engine
   import vde_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write_enable,
   input  logic [1:0]               csr_write_data,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [ELEM_W-1:0] req_query_element,
   input  logic signed [ELEM_W-1:0] req_candidate_element,
   input  logic                     req_last_element,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [SUM_W-1:0]  rsp_distance
);

   logic [1:0] metric_ff;
   logic       f_valid, f_stall, b_valid, b_stall;
   row_type    f_row, b_row;

   // metric register
   always_ff @(posedge clock) begin
      if (reset) metric_ff <= METRIC_L2;
      else if (csr_write_enable) metric_ff <= csr_write_data;
   end

   vde_front u_front (
      .clock, .reset, .metric(metric_ff),
      .in_valid(req_valid), .in_stall(req_stall),
      .qe(req_query_element), .ce(req_candidate_element), .last(req_last_element),
      .row_valid(f_valid), .row_stall(f_stall), .row(f_row)
   );

   vde_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock, .reset,
      .wr_valid(f_valid), .wr_stall(f_stall), .wr_data(f_row),
      .rd_valid(b_valid), .rd_stall(b_stall), .rd_data(b_row)
   );

   vde_back u_back (
      .clock, .reset,
      .row_valid(b_valid), .row_stall(b_stall), .row(b_row),
      .out_valid(rsp_valid), .out_stall(rsp_stall), .out_dist(rsp_distance)
   );

endmodule
